FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the xz block header parser.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/xzbh_pkg.sv
// Package for the xz block header dictionary size parser: parse phases,
// state record, constants and the bitwise CRC-32 byte update. No dependencies.
package xzbh_pkg;

	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [7:0]  LZMA2_ID   = 8'h21;
	localparam logic [7:0]  FLAG_RSVD  = 8'h3C;
	localparam logic [7:0]  FLAG_CSIZE = 8'h40;
	localparam logic [7:0]  FLAG_USIZE = 8'h80;
	localparam logic [7:0]  PROP_MAX   = 8'd39;
	localparam logic [10:0] COUNT_MAX  = 11'd1036;
	localparam logic [10:0] MIN_TOTAL  = 11'd24;
	localparam logic [10:0] MIN_HDR    = 11'd8;
	localparam logic [10:0] POS_SIZE   = 11'd12;
	localparam logic [10:0] POS_FLAGS  = 11'd13;
	localparam logic [10:0] POS_FIRST  = 11'd14;
	localparam logic [10:0] MAGIC_LEN  = 11'd6;
	localparam logic [3:0]  VLI_LAST   = 4'd8;

	typedef enum logic [8:0] {
		PH_IDLE  = 9'b000000001,
		PH_CSIZE = 9'b000000010,
		PH_USIZE = 9'b000000100,
		PH_FID   = 9'b000001000,
		PH_PSIZE = 9'b000010000,
		PH_SKIP  = 9'b000100000,
		PH_PROP  = 9'b001000000,
		PH_DONE  = 9'b010000000,
		PH_FAIL  = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [10:0] cnt;     // bytes seen, saturating
		logic        magic;
		logic [10:0] hlen;    // header length in bytes
		logic [7:0]  flags;
		logic [31:0] crc;
		logic [31:0] expect_crc;
		phase_t      phase;
		logic [10:0] acc;     // low bits of the open VLI
		logic        big;     // open VLI has a bit above acc
		logic [3:0]  shift;
		logic [2:0]  filt;
		logic [10:0] pleft;
		logic        lzma2;
		logic [31:0] dict;
	} st_t;

	localparam st_t ST_RESET = '{
		cnt: 11'd0, magic: 1'b1, hlen: 11'd0, flags: 8'd0, crc: 32'hFFFFFFFF,
		expect_crc: 32'd0, phase: PH_IDLE, acc: 11'd0, big: 1'b0, shift: 4'd0,
		filt: 3'd0, pleft: 11'd0, lzma2: 1'b0, dict: 32'd0
	};

	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] m;
		case (idx)
			3'd0:    m = 8'hFD;
			3'd1:    m = 8'h37;
			3'd2:    m = 8'h7A;
			3'd3:    m = 8'h58;
			3'd4:    m = 8'h5A;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

FILE: sv/xz_block_header_dict_size_parser_unit.sv
// An input transfer is held in the input register; its result is held in the result register.
// Throughput: one byte per cycle; the byte with last_byte set needs a free result slot.
// Parse state advances on the input register; one CRC-32 byte update per accepted header byte.
// arst_n clears the valid flags and the parse state; a delivered last byte also returns the state to reset.
// Depends on xzbh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xz_block_header_dict_size_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        header_ok,
	output logic [31:0] dict_size
);
	import xzbh_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        s1_fire;
	logic        out_free;
	logic        out_valid_q;
	logic        ok_q;
	logic [31:0] dict_q;
	st_t         st_q;
	st_t         st_d;
	logic        ok_d;

	// combinational helpers
	logic [10:0] pos;
	logic [11:0] pos12;
	logic [11:0] crc_end;
	logic [11:0] exp_end;
	logic [1:0]  exp_idx;
	logic [10:0] acc_new;
	logic        big_new;
	logic        vli_err;
	logic [10:0] rem;
	logic [2:0]  filt_dec;
	logic [10:0] pleft_dec;
	logic [4:0]  dsh;

	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	always_comb begin
		st_d      = st_q;
		pos       = st_q.cnt;
		pos12     = {1'b0, pos};
		acc_new   = st_q.acc;
		big_new   = st_q.big;
		vli_err   = 1'b0;
		rem       = '0;
		exp_idx   = '0;
		dsh       = '0;
		filt_dec  = (st_q.filt != 3'd0) ? st_q.filt - 3'd1 : 3'd0;
		pleft_dec = (st_q.pleft != 11'd0) ? st_q.pleft - 11'd1 : 11'd0;

		if (pos < MAGIC_LEN && byte_s1 != magic_byte(pos[2:0]))
			st_d.magic = 1'b0;
		if (pos == POS_SIZE)
			st_d.hlen = 11'({1'b0, byte_s1, 2'b00}) + 11'd4;
		crc_end = {1'b0, st_d.hlen} + 12'd8;
		exp_end = {1'b0, st_d.hlen} + 12'd12;

		if (pos >= POS_SIZE) begin
			if (pos12 < crc_end) begin
				st_d.crc = crc_byte(st_q.crc, byte_s1);
			end else if (pos12 < exp_end) begin
				exp_idx = 2'(pos12 - crc_end);
				st_d.expect_crc = st_q.expect_crc | (32'(byte_s1) << {exp_idx, 3'b000});
			end
		end

		if (pos == POS_FLAGS) begin
			st_d.flags = byte_s1;
			st_d.filt  = {1'b0, byte_s1[1:0]} + 3'd1;
			if ((byte_s1 & FLAG_CSIZE) != 8'd0)
				st_d.phase = PH_CSIZE;
			else if ((byte_s1 & FLAG_USIZE) != 8'd0)
				st_d.phase = PH_USIZE;
			else
				st_d.phase = PH_FID;
			if ((byte_s1 & FLAG_RSVD) != 8'd0)
				st_d.phase = PH_FAIL;
		end

		// VLI digit: the value is only compared against small numbers, so bits
		// above the low eleven collapse into one flag
		case (st_q.shift)
			4'd0: acc_new = st_q.acc | {4'd0, byte_s1[6:0]};
			4'd1: begin
				acc_new = st_q.acc | {byte_s1[3:0], 7'd0};
				big_new = st_q.big | (byte_s1[6:4] != 3'd0);
			end
			default: big_new = st_q.big | (byte_s1[6:0] != 7'd0);
		endcase
		vli_err = (st_q.shift > VLI_LAST) ||
			(st_q.shift == VLI_LAST && byte_s1[7:1] != 7'd0);
		rem = 11'(crc_end - pos12 - 12'd1);

		if (pos >= POS_FIRST && pos12 < crc_end) begin
			if (st_q.phase inside {PH_CSIZE, PH_USIZE, PH_FID, PH_PSIZE}) begin
				if (vli_err) begin
					st_d.phase = PH_FAIL;
				end else if (byte_s1[7]) begin
					st_d.shift = st_q.shift + 4'd1;
					st_d.acc   = acc_new;
					st_d.big   = big_new;
				end else if (st_q.shift != 4'd0 && byte_s1 == 8'd0) begin
					st_d.phase = PH_FAIL;
				end else begin
					st_d.shift = '0;
					st_d.acc   = '0;
					st_d.big   = 1'b0;
					case (st_q.phase)
						PH_CSIZE: begin
							st_d.phase = ((st_q.flags & FLAG_USIZE) != 8'd0) ? PH_USIZE : PH_FID;
						end
						PH_USIZE: st_d.phase = PH_FID;
						PH_FID: begin
							st_d.lzma2 = !big_new && acc_new == 11'(LZMA2_ID);
							st_d.phase = PH_PSIZE;
						end
						default: begin
							if (big_new || acc_new > rem) begin
								st_d.phase = PH_FAIL;
							end else if (st_q.lzma2) begin
								st_d.phase = (acc_new == 11'd1) ? PH_PROP : PH_FAIL;
							end else if (acc_new == 11'd0) begin
								st_d.filt  = filt_dec;
								st_d.phase = (filt_dec == 3'd0) ? PH_FAIL : PH_FID;
							end else begin
								st_d.pleft = acc_new;
								st_d.phase = PH_SKIP;
							end
						end
					endcase
				end
			end else if (st_q.phase == PH_SKIP) begin
				st_d.pleft = pleft_dec;
				if (pleft_dec == 11'd0) begin
					st_d.filt  = filt_dec;
					st_d.phase = (filt_dec == 3'd0) ? PH_FAIL : PH_FID;
				end
			end else if (st_q.phase == PH_PROP) begin
				if (byte_s1 > PROP_MAX) begin
					st_d.phase = PH_FAIL;
				end else begin
					dsh        = 5'(byte_s1[5:1]) + 5'd11;
					st_d.dict  = {30'd0, 1'b1, byte_s1[0]} << dsh;
					st_d.phase = PH_DONE;
				end
			end
		end

		if (st_q.cnt < COUNT_MAX)
			st_d.cnt = st_q.cnt + 11'd1;

		ok_d = st_d.magic && st_d.phase == PH_DONE && st_d.cnt >= MIN_TOTAL &&
			st_d.hlen >= MIN_HDR && {1'b0, st_d.cnt} >= exp_end &&
			~st_d.crc == st_d.expect_crc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= ST_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (s1_fire)
				st_q <= last_s1 ? ST_RESET : st_d;
			if (s1_fire && last_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (s1_fire && last_s1) begin
			ok_q   <= ok_d;
			dict_q <= ok_d ? st_d.dict : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign header_ok = ok_q;
	assign dict_size = dict_q;

	`ASSERT_CLK(a_result_from_last, $rose(out_valid_q) |-> $past(valid_s1 && last_s1), "result without a last byte")
	`ASSERT_CLK(a_not_ok_zero_dict, (out_valid_q && !ok_q) |-> (dict_q == 32'd0), "dictionary size set on a failed header")
	`ASSERT_CLK(a_state_cleared, (s1_fire && last_s1) |=> (st_q.cnt == 11'd0 && st_q.phase == PH_IDLE), "state not cleared after the last byte")
	`ASSERT_CLK(a_count_sat, st_q.cnt <= COUNT_MAX, "byte count beyond saturation")
	`ASSERT_CLK(a_no_drop, (valid_s1 && last_s1 && !out_free) |=> (valid_s1 && last_s1), "last byte dropped while result slot busy")

endmodule

FILE: tb/xz_block_header_dict_size_parser_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for xz_block_header_dict_size_parser_unit: whole xz images go in one byte per
// transfer; a built-in parser model predicts each verdict. Depends on xzbh_pkg and the RTL.
module xz_block_header_dict_size_parser_unit_tb;
	import xzbh_pkg::*;

	localparam logic [47:0] XZ_MAGIC = 48'hFD_37_7A_58_5A_00;
	localparam logic [7:0]  FILTER_COUNT_MASK = 8'h03;

	typedef struct packed {
		logic        ok;
		logic [31:0] size;
	} dict_verdict_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        header_ok;
	logic [31:0] dict_size;

	xz_block_header_dict_size_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.header_ok (header_ok),
		.dict_size (dict_size)
	);

	dict_verdict_t pending_verdicts[$];
	logic [7:0]    hdr_body[$];
	logic [7:0]    file_img[$];

	int tx_gap_pct = 36;
	int rx_gap_pct = 36;
	int errors = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int verdicts_seen = 0;
	int dict_hits = 0;

	// parser model state
	int unsigned p_count;
	bit          p_magic_ok;
	int unsigned p_hlen;
	logic [7:0]  p_flags;
	logic [31:0] p_crc;
	logic [31:0] p_crc_field;
	phase_t      p_phase;
	logic [63:0] p_vacc;
	int unsigned p_vstep;
	int unsigned p_filters;
	int unsigned p_skip;
	bit          p_is_lzma2;
	bit          p_have_dict;
	logic [31:0] p_dict;
	bit          p_bad;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [7:0] magic_at(input int i);
		return 8'(XZ_MAGIC >> (8 * (5 - i)));
	endfunction

	function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic parser_model_clear();
		p_count = 0;
		p_magic_ok = 1'b1;
		p_hlen = 0;
		p_flags = 8'h00;
		p_crc = 32'hFFFF_FFFF;
		p_crc_field = 32'd0;
		p_phase = PH_IDLE;
		p_vacc = 64'd0;
		p_vstep = 0;
		p_filters = 0;
		p_skip = 0;
		p_is_lzma2 = 1'b0;
		p_have_dict = 1'b0;
		p_dict = 32'd0;
		p_bad = 1'b0;
	endtask

	task automatic parser_model_reject();
		p_phase = PH_FAIL;
		p_bad = 1'b1;
	endtask

	// -1 on a malformed VLI, 0 while it is open, 1 when complete
	function automatic int vli_take(input logic [7:0] b, output logic [63:0] v);
		v = 64'd0;
		if (p_vstep > 8)
			return -1;
		if (p_vstep == 8 && (b & 8'hFE) != 0)
			return -1;
		p_vacc |= 64'(b[6:0]) << (7 * p_vstep);
		if (!b[7]) begin
			if (p_vstep != 0 && b == 8'h00)
				return -1;
			v = p_vacc;
			p_vacc = 64'd0;
			p_vstep = 0;
			return 1;
		end
		p_vstep++;
		return 0;
	endfunction

	task automatic filter_done();
		if (p_filters > 0)
			p_filters--;
		if (p_filters == 0)
			parser_model_reject();
		else
			p_phase = PH_FID;
	endtask

	task automatic parse_header_byte(input logic [7:0] b, input int unsigned pos,
			input int unsigned limit);
		logic [63:0] v;
		int r;
		case (p_phase)
		PH_CSIZE, PH_USIZE, PH_FID, PH_PSIZE: begin
			r = vli_take(b, v);
			if (r < 0) begin
				parser_model_reject();
			end else if (r > 0) begin
				case (p_phase)
				PH_CSIZE: p_phase = ((p_flags & FLAG_USIZE) != 0) ? PH_USIZE : PH_FID;
				PH_USIZE: p_phase = PH_FID;
				PH_FID: begin
					p_is_lzma2 = (v == 64'(LZMA2_ID));
					p_phase = PH_PSIZE;
				end
				default: begin
					if (v > 64'(limit - pos - 1))
						parser_model_reject();
					else if (p_is_lzma2) begin
						if (v != 64'd1)
							parser_model_reject();
						else
							p_phase = PH_PROP;
					end else if (v == 64'd0)
						filter_done();
					else begin
						p_skip = v[31:0];
						p_phase = PH_SKIP;
					end
				end
				endcase
			end
		end
		PH_SKIP: begin
			if (p_skip > 0)
				p_skip--;
			if (p_skip == 0)
				filter_done();
		end
		PH_PROP: begin
			if (b > PROP_MAX)
				parser_model_reject();
			else begin
				p_dict = (32'd2 + 32'(b[0])) << (32'(b >> 1) + 11);
				p_have_dict = 1'b1;
				p_phase = PH_DONE;
			end
		end
		default: ;
		endcase
	endtask

	task automatic parser_model_step(input logic [7:0] b, input logic fin,
			output bit produced, output dict_verdict_t vr);
		int unsigned pos;
		int unsigned total;
		bit ok;
		pos = p_count;
		produced = 1'b0;
		vr = '0;
		if (pos < MAGIC_LEN && b != magic_at(pos))
			p_magic_ok = 1'b0;
		if (pos == POS_SIZE)
			p_hlen = (int'(b) + 1) * 4;
		if (pos >= POS_SIZE) begin
			if (pos < 8 + p_hlen)
				p_crc = crc32_update(p_crc, b);
			else if (pos < 12 + p_hlen)
				p_crc_field |= 32'(b) << (8 * (pos - 8 - p_hlen));
		end
		if (pos == POS_FLAGS) begin
			p_flags = b;
			p_filters = int'(b & FILTER_COUNT_MASK) + 1;
			if ((b & FLAG_CSIZE) != 0)
				p_phase = PH_CSIZE;
			else if ((b & FLAG_USIZE) != 0)
				p_phase = PH_USIZE;
			else
				p_phase = PH_FID;
			if ((b & FLAG_RSVD) != 0)
				parser_model_reject();
		end
		if (pos >= POS_FIRST && pos < 8 + p_hlen)
			parse_header_byte(b, pos, 8 + p_hlen);
		if (p_count < COUNT_MAX)
			p_count++;
		if (fin) begin
			total = p_count;
			ok = p_magic_ok && !p_bad && total >= MIN_TOTAL && p_hlen >= MIN_HDR &&
				total >= 12 + p_hlen && ~p_crc == p_crc_field && p_have_dict;
			produced = 1'b1;
			vr.ok = ok;
			vr.size = ok ? p_dict : 32'd0;
			parser_model_clear();
		end
	endtask

	// result side: random stalls, compare against the oldest prediction
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_gap_pct);

	always @(posedge clk) begin
		dict_verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: header_ok=%0d dict_size=%0h",
					header_ok, dict_size);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_seen++;
				if (want.ok)
					dict_hits++;
				if (header_ok !== want.ok) begin
					$error("header_ok: expected %0d, got %0d", want.ok, header_ok);
					errors++;
				end
				if (dict_size !== want.size) begin
					$error("dict_size: expected %0h, got %0h", want.size,
						dict_size);
					errors++;
				end
			end
		end
	end

	// entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		bit got;
		dict_verdict_t vr;
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		parser_model_step(b, fin, got, vr);
		if (got)
			pending_verdicts.push_back(vr);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_image();
		foreach (file_img[i])
			send_byte(file_img[i], i == file_img.size() - 1);
		files_sent++;
	endtask

	task automatic push_vli(input logic [63:0] v);
		do begin
			hdr_body.push_back({v >= 64'd128, v[6:0]});
			v = v >> 7;
		end while (v != 64'd0);
	endtask

	task automatic begin_body(input logic [7:0] fl);
		hdr_body.delete();
		hdr_body.push_back(fl);
	endtask

	task automatic push_lzma2(input logic [7:0] p);
		hdr_body.push_back(LZMA2_ID);
		hdr_body.push_back(8'h01);
		hdr_body.push_back(p);
	endtask

	// size byte + body + padding + CRC, behind magic and stream flags
	task automatic assemble_image(input int extra_words, input bit junk_pad, input int trail);
		logic [7:0] hdr[$];
		logic [31:0] c;
		int words;
		words = (hdr_body.size() + 8) / 4 + extra_words;
		if (words > 256)
			words = 256;
		hdr.push_back(8'(words - 1));
		foreach (hdr_body[i])
			hdr.push_back(hdr_body[i]);
		while (hdr.size() < words * 4 - 4)
			hdr.push_back(junk_pad ? 8'($urandom) : 8'h00);
		c = 32'hFFFF_FFFF;
		foreach (hdr[i])
			c = crc32_update(c, hdr[i]);
		c = ~c;
		file_img.delete();
		for (int i = 0; i < 6; i++)
			file_img.push_back(magic_at(i));
		repeat (6) file_img.push_back(8'($urandom));
		foreach (hdr[i])
			file_img.push_back(hdr[i]);
		for (int i = 0; i < 4; i++)
			file_img.push_back(8'(c >> (8 * i)));
		repeat (trail) file_img.push_back(8'($urandom));
	endtask

	task automatic build_plain(input logic [7:0] p, input int trail);
		begin_body(8'h00);
		push_lzma2(p);
		assemble_image(0, 1'b0, trail);
	endtask

	function automatic logic [63:0] random_vli();
		logic [63:0] v;
		int w;
		if ($urandom_range(0, 1) == 0)
			return 64'($urandom_range(0, 300));
		w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 56);
		v = {$urandom, $urandom};
		return v & ((64'd1 << w) - 64'd1);
	endfunction

	task automatic gen_random_body();
		int nf;
		int lz_at;
		int sz;
		logic [7:0] fl;
		logic [63:0] id;
		nf = $urandom_range(1, 4);
		fl = 8'(nf - 1);
		if ($urandom_range(0, 2) == 0)
			fl |= FLAG_CSIZE;
		if ($urandom_range(0, 2) == 0)
			fl |= FLAG_USIZE;
		begin_body(fl);
		if ((fl & FLAG_CSIZE) != 0)
			push_vli(random_vli());
		if ((fl & FLAG_USIZE) != 0)
			push_vli(random_vli());
		// lz_at == nf: no LZMA2 filter at all
		lz_at = ($urandom_range(0, 9) == 0) ? nf : $urandom_range(0, nf - 1);
		for (int i = 0; i < nf; i++) begin
			if (i == lz_at) begin
				push_lzma2(($urandom_range(0, 7) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 39)));
			end else begin
				id = random_vli();
				if (id == 64'(LZMA2_ID))
					id++;
				push_vli(id);
				sz = $urandom_range(0, 3);
				hdr_body.push_back(8'(sz));
				repeat (sz) hdr_body.push_back(8'($urandom));
			end
		end
	endtask

	task automatic test_dictionary_sizes();
		build_plain(8'd0, 0);
		send_image();
		// both optional sizes, four filters, LZMA2 last with the largest property
		begin_body(FLAG_CSIZE | FLAG_USIZE | 8'h03);
		push_vli(64'd1000);
		push_vli(64'h00FF_FFFF_FFFF_FFFF);
		hdr_body = {hdr_body, 8'h03, 8'h01, 8'h55, 8'h04, 8'h00, 8'h09, 8'h02, 8'hAA, 8'hBB};
		push_lzma2(PROP_MAX);
		assemble_image(0, 1'b0, 5);
		send_image();
		build_plain(8'd17, 3);
		send_image();
	endtask

	task automatic test_short_inputs();
		file_img = {8'($urandom)};
		send_image();
		build_plain(8'd5, 0);
		void'(file_img.pop_back());
		send_image();
		build_plain(8'd6, 4);
		void'(file_img.pop_back());
		repeat (4) void'(file_img.pop_back());
		send_image();
		build_plain(8'd7, 0);
		send_image();
	endtask

	task automatic test_header_fields();
		int hl;
		// header size byte of zero
		file_img.delete();
		for (int i = 0; i < 6; i++)
			file_img.push_back(magic_at(i));
		repeat (6) file_img.push_back(8'h00);
		file_img.push_back(8'h00);
		repeat (20) file_img.push_back(8'($urandom));
		send_image();
		begin_body(8'h04);
		push_lzma2(8'd3);
		assemble_image(0, 1'b0, 2);
		send_image();
		build_plain(8'd3, 2);
		file_img[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
		send_image();
		build_plain(8'd3, 2);
		hl = (int'(file_img[12]) + 1) * 4;
		file_img[8 + hl] ^= 8'h10;
		send_image();
	endtask

	task automatic test_vli_rules();
		// nine-byte VLI: last byte 1 is legal, 2 is not
		begin_body(FLAG_USIZE);
		repeat (8) hdr_body.push_back(8'hFF);
		hdr_body.push_back(8'h01);
		push_lzma2(8'd20);
		assemble_image(0, 1'b0, 0);
		send_image();
		begin_body(FLAG_USIZE);
		repeat (8) hdr_body.push_back(8'hFF);
		hdr_body.push_back(8'h02);
		push_lzma2(8'd20);
		assemble_image(0, 1'b0, 0);
		send_image();
		// non-minimal encoding
		begin_body(FLAG_CSIZE);
		hdr_body = {hdr_body, 8'h85, 8'h00};
		push_lzma2(8'd20);
		assemble_image(0, 1'b0, 0);
		send_image();
		// filter ID still open when the CRC field begins
		begin_body(8'h00);
		hdr_body = {hdr_body, 8'h81, 8'h80};
		assemble_image(0, 1'b0, 8);
		send_image();
	endtask

	task automatic test_filter_rules();
		begin_body(8'h01);
		hdr_body = {hdr_body, 8'h03, 8'h7F};
		push_lzma2(8'd1);
		assemble_image(0, 1'b0, 4);
		send_image();
		begin_body(8'h00);
		hdr_body = {hdr_body, LZMA2_ID, 8'h02, 8'h10, 8'h10};
		assemble_image(0, 1'b0, 4);
		send_image();
		build_plain(PROP_MAX + 8'd1, 4);
		send_image();
		begin_body(8'h01);
		hdr_body = {hdr_body, 8'h03, 8'h01, 8'hAA, 8'h04, 8'h00};
		assemble_image(0, 1'b0, 4);
		send_image();
		// LZMA2 second; garbage after it and in the padding is ignored
		begin_body(8'h03);
		hdr_body = {hdr_body, 8'h0A, 8'h02, 8'h5A, 8'hA5};
		push_lzma2(8'd22);
		hdr_body = {hdr_body, 8'hFF, 8'hFF, 8'h00};
		assemble_image(2, 1'b1, 4);
		send_image();
	endtask

	task automatic test_long_header();
		// largest header, then enough trailing bytes to saturate the byte count
		build_plain(8'd38, 0);
		begin_body(8'h00);
		push_lzma2(8'd38);
		assemble_image(300, 1'b1, 4);
		send_image();
	endtask

	task automatic test_random_files();
		int n;
		int pick;
		int cut;
		int hl;
		n = 0;
		while (n < 8) begin
			// one long burst with no stalls on either side
			tx_gap_pct = (n >= 1 && n < 6) ? 0 : 36;
			rx_gap_pct = tx_gap_pct;
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				file_img.delete();
				repeat ($urandom_range(1, 48)) file_img.push_back(8'($urandom));
			end else begin
				gen_random_body();
				if (pick >= 60 && pick < 72)
					hdr_body[$urandom_range(0, hdr_body.size() - 1)] ^=
						8'(1 << $urandom_range(0, 7));
				assemble_image(($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
					$urandom_range(0, 3) == 0, $urandom_range(0, 6));
				hl = (int'(file_img[12]) + 1) * 4;
				if (pick >= 72 && pick < 80)
					file_img[8 + hl + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
				else if (pick >= 80 && pick < 88) begin
					cut = $urandom_range(1, file_img.size() - 1);
					while (file_img.size() > cut)
						void'(file_img.pop_back());
				end else if (pick >= 88 && pick < 94)
					file_img[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
			end
			send_image();
			n++;
		end
		tx_gap_pct = 36;
		rx_gap_pct = 36;
	endtask

	initial begin
		int w;
		parser_model_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_dictionary_sizes();
		test_short_inputs();
		test_header_fields();
		test_vli_rules();
		test_filter_rules();
		test_long_header();
		test_random_files();
		in_valid <= 1'b0;

		for (w = 0; w < 5000 && pending_verdicts.size() != 0; w++)
			@(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", pending_verdicts.size());
			errors++;
		end
		repeat (10) @(posedge clk);

		$display("Parsed %0d xz images (%0d byte transfers); %0d verdicts checked, %0d of them with a dictionary size.",
			files_sent, bytes_sent, verdicts_seen, dict_hits);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/xzbh_pkg.sv
sv/xz_block_header_dict_size_parser_unit.sv
tb/xz_block_header_dict_size_parser_unit_tb.sv
